### rtl/imu_calibrate_and_smooth_assert.svh
// Assertion macros shared by the IMU conditioning modules
`ifndef IMU_CALIBRATE_AND_SMOOTH_ASSERT_SVH
`define IMU_CALIBRATE_AND_SMOOTH_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define IMUCAS_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("imucas assertion failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define IMUCAS_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("imucas assertion failed");

`endif

### rtl/imucas_pkg.sv
// Shared types, codes and constants of the IMU conditioning block
`default_nettype none
package imucas_pkg;

    localparam int AXES             = 6;
    localparam int AXIS_AZ          = 2;
    localparam int CALIB_SAMPLES_DEF = 100;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CFG_DATA_W       = 16;
    localparam int INTERVAL_W       = 10;
    localparam int GRAVITY_W        = 15;
    localparam int ALPHA_W          = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd10;
    localparam logic [GRAVITY_W-1:0]  GRAVITY_RESET  = 15'd16384;
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 16'd9830;
    localparam logic [ALPHA_W:0]      ALPHA_ONE      = 17'd32768;

    typedef logic signed [15:0] axis_t;
    typedef axis_t [AXES-1:0] axes_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_GRAVITY  = 2'd1,
        CFG_ALPHA    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] temperature;
        logic               want_calibrated;
        logic               want_filtered;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_gyro_x;
        logic signed [15:0] out_gyro_y;
        logic signed [15:0] out_gyro_z;
        logic signed [15:0] out_temperature;
        logic               is_calibrating;
        logic               is_calibrated;
    } out_item_t;

    typedef struct packed {
        logic calibrating;
        logic offsets_valid;
        logic finishing;
    } calib_status_t;

endpackage
`default_nettype wire

### rtl/imucas_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer
`default_nettype none
interface imucas_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/imucas_calib.sv
// Calibration sequencer: interval timing, per-axis sums and offset division
`default_nettype none
`include "imu_calibrate_and_smooth_assert.svh"
module imucas_calib import imucas_pkg::*; #(
    parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [1:0]            kind,
    input  wire axes_t                 samples,
    input  wire logic [INTERVAL_W-1:0] interval,
    input  wire logic [GRAVITY_W-1:0]  gravity,
    output calib_status_t              status,
    output axes_t                      offsets
);

    localparam int CW     = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CW;
    localparam int K      = SUM_W + CW;
    localparam int PROD_W = SUM_W + K + 1;
    localparam int AVG_W  = 18;
    localparam longint unsigned RECIP_L =
        ((64'd1 << K) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
    localparam logic [K:0] RECIP = RECIP_L[K:0];

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE
    } phase_t;

    phase_t                  phase_reg;
    logic [INTERVAL_W-1:0]   ms_reg;
    logic [CW-1:0]           count_reg;
    logic signed [SUM_W-1:0] sums_reg [AXES];
    axes_t                   offsets_reg;
    logic                    valid_reg;
    logic                    finish_reg;

    logic [INTERVAL_W-1:0]   ms_inc;
    logic [CW-1:0]           count_inc;
    logic                    take;
    logic                    last;
    logic signed [SUM_W-1:0] smp_ext [AXES];
    axes_t                   offsets_calc;

    assign ms_inc    = (ms_reg != {INTERVAL_W{1'b1}}) ? ms_reg + 1'b1 : ms_reg;
    assign take      = (ms_inc >= interval);
    assign count_inc = count_reg + 1'b1;
    assign last      = (count_inc >= CW'(CALIB_SAMPLES));

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        logic                    neg;
        logic [SUM_W-1:0]        mag;
        logic [PROD_W-1:0]       prod;
        logic [SAMPLE_BITS-1:0]  quot;
        logic signed [AVG_W-1:0] avg;
        logic signed [AVG_W-1:0] adj;

        assign smp_ext[g] = SUM_W'(signed'(samples[g][SAMPLE_BITS-1:0]));

        assign neg  = sums_reg[g][SUM_W-1];
        assign mag  = neg ? SUM_W'(-sums_reg[g]) : SUM_W'(sums_reg[g]);
        assign prod = PROD_W'(mag) * PROD_W'(RECIP);
        assign quot = prod[K +: SAMPLE_BITS];
        assign avg  = neg ? -AVG_W'(quot) : AVG_W'(quot);
        assign adj  = (g == AXIS_AZ) ? avg - AVG_W'(gravity) : avg;
        assign offsets_calc[g] = adj[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ms_reg      <= '0;
            count_reg   <= '0;
            offsets_reg <= '0;
            valid_reg   <= 1'b0;
            finish_reg  <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            finish_reg <= 1'b0;
            if (finish_reg)
            begin
                offsets_reg <= offsets_calc;
            end
            if (accept)
            begin
                case (kind)
                    KIND_START:
                    begin
                        if (phase_reg == PH_IDLE)
                        begin
                            phase_reg <= PH_RUN;
                            ms_reg    <= '0;
                            count_reg <= '0;
                            valid_reg <= 1'b0;
                            for (int i = 0; i < AXES; i++)
                            begin
                                sums_reg[i] <= '0;
                            end
                        end
                    end
                    KIND_TICK:
                    begin
                        case (phase_reg)
                            PH_RUN:
                            begin
                                ms_reg <= take ? '0 : ms_inc;
                                if (take)
                                begin
                                    count_reg <= count_inc;
                                    for (int i = 0; i < AXES; i++)
                                    begin
                                        sums_reg[i] <= sums_reg[i] + smp_ext[i];
                                    end
                                    if (last)
                                    begin
                                        phase_reg  <= PH_DONE;
                                        valid_reg  <= 1'b1;
                                        finish_reg <= 1'b1;
                                    end
                                end
                            end
                            PH_DONE:
                            begin
                                phase_reg <= PH_IDLE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign status = '{
        calibrating:   (phase_reg == PH_RUN),
        offsets_valid: valid_reg,
        finishing:     finish_reg
    };
    assign offsets = offsets_reg;

    `IMUCAS_ASSERT_NEXT(a_last_sample_finishes,
        accept && kind == KIND_TICK && phase_reg == PH_RUN && take && last, finish_reg)
    `IMUCAS_ASSERT_NEXT(a_finish_is_pulse, finish_reg, !finish_reg)
    `IMUCAS_ASSERT_NOW(a_finish_in_done, finish_reg, valid_reg && phase_reg == PH_DONE)

endmodule
`default_nettype wire

### rtl/imucas_filter.sv
// Offset subtraction and exponential smoothing lanes, one per axis
`default_nettype none
module imucas_filter import imucas_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire axes_t              samples,
    input  wire logic               use_offsets,
    input  wire axes_t              offsets,
    input  wire logic               filtered,
    input  wire logic [ALPHA_W-1:0] alpha,
    output axes_t                   result
);

    localparam int ACC_W = 36;

    axes_t            smooth_reg;
    axes_t            smooth_next;
    logic [ALPHA_W:0] weight;

    assign weight = (17'(alpha) > ALPHA_ONE) ? ALPHA_ONE : 17'(alpha);

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        axis_t                   corrected;
        logic signed [16:0]      diff;
        logic signed [34:0]      prod;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] acc_adj;

        assign corrected = use_offsets ? axis_t'(samples[g] - offsets[g]) : samples[g];
        assign diff      = 17'(corrected) - 17'(smooth_reg[g]);
        assign prod      = 35'(diff) * 35'(signed'({1'b0, weight}));
        assign acc       = (ACC_W'(smooth_reg[g]) <<< 15) + ACC_W'(prod);
        assign acc_adj   = acc[ACC_W-1] ? acc + ACC_W'(32767) : acc;
        assign smooth_next[g] = acc_adj[30:15];
        assign result[g] = filtered ? smooth_next[g] : corrected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
        end
        else if (update)
        begin
            smooth_reg <= smooth_next;
        end
    end

endmodule
`default_nettype wire

### rtl/imu_calibrate_and_smooth.sv
// Top level of the six-axis IMU calibration and smoothing block
// Usage:
//   in_ch carries start, millisecond tick and read items; out_ch returns one
//   result per read. Starts and ticks give no result.
//   cfg_we/cfg_index/cfg_data write sample interval, gravity count and filter
//   weight; write them only while the block is idle.
// Timing and throughput:
//   A read's result is registered and presented in the cycle after its transfer.
//   One item is taken every cycle unless in_ch.ready is held low by a stall; the
//   output register is reloaded in the same cycle that its previous result is taken.
//   After the tick that completes a calibration, in_ch.ready drops low for a single
//   cycle while the offset divider writes the six offsets.
// Reset:
//   rst_n clears the calibration phase, counters, sums, offsets, the
//   smoothed values and the output valid flag; registers return to defaults.
// Stalls:
//   While a result waits on out_ch.ready low, no new item is taken; the
//   result holds until it is transferred.
`default_nettype none
`include "imu_calibrate_and_smooth_assert.svh"
module imu_calibrate_and_smooth import imucas_pkg::*; #(
    parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    imucas_stream_if.sink              in_ch,
    imucas_stream_if.source            out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [INTERVAL_W-1:0] interval_reg;
    logic [GRAVITY_W-1:0]  gravity_reg;
    logic [ALPHA_W-1:0]    alpha_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_data_reg;
    in_item_t      item;
    logic          accept;
    logic          read_accept;
    axes_t         samples;
    axes_t         offsets;
    axes_t         result;
    calib_status_t status;

    assign item         = in_ch.data;
    assign in_ch.ready  = (!out_valid_reg || out_ch.ready) && !status.finishing;
    assign accept       = in_ch.valid && in_ch.ready;
    assign read_accept  = accept && (item.kind == KIND_READ);

    assign samples[0] = 16'(signed'(item.accel_x[SAMPLE_BITS-1:0]));
    assign samples[1] = 16'(signed'(item.accel_y[SAMPLE_BITS-1:0]));
    assign samples[2] = 16'(signed'(item.accel_z[SAMPLE_BITS-1:0]));
    assign samples[3] = 16'(signed'(item.gyro_x[SAMPLE_BITS-1:0]));
    assign samples[4] = 16'(signed'(item.gyro_y[SAMPLE_BITS-1:0]));
    assign samples[5] = 16'(signed'(item.gyro_z[SAMPLE_BITS-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            gravity_reg  <= GRAVITY_RESET;
            alpha_reg    <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_GRAVITY:  gravity_reg  <= cfg_data[GRAVITY_W-1:0];
                CFG_ALPHA:    alpha_reg    <= cfg_data[ALPHA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    imucas_calib #(
        .CALIB_SAMPLES (CALIB_SAMPLES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_calib (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (item.kind),
        .samples  (samples),
        .interval (interval_reg),
        .gravity  (gravity_reg),
        .status   (status),
        .offsets  (offsets)
    );

    imucas_filter u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (read_accept && item.want_filtered),
        .samples     (samples),
        .use_offsets (item.want_calibrated && status.offsets_valid),
        .offsets     (offsets),
        .filtered    (item.want_filtered),
        .alpha       (alpha_reg),
        .result      (result)
    );

    assign out_valid_next = read_accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_accept)
        begin
            out_data_reg <= '{
                out_accel_x:     result[0],
                out_accel_y:     result[1],
                out_accel_z:     result[2],
                out_gyro_x:      result[3],
                out_gyro_y:      result[4],
                out_gyro_z:      result[5],
                out_temperature: item.temperature,
                is_calibrating:  status.calibrating,
                is_calibrated:   status.offsets_valid
            };
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    `IMUCAS_ASSERT_NOW(a_hold_while_finishing, status.finishing, !in_ch.ready)
    `IMUCAS_ASSERT_NEXT(a_read_gives_result, read_accept, out_valid_reg)
    `IMUCAS_ASSERT_NEXT(a_tick_no_result,
        accept && item.kind == KIND_TICK && !out_valid_reg, !out_valid_reg)

endmodule
`default_nettype wire

### dv/imu_calibrate_and_smooth_tb.sv
// Self-checking testbench for the IMU calibration and smoothing block
module imu_calibrate_and_smooth_tb;
    import imucas_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SAMPLES_PER_CAL = CALIB_SAMPLES_DEF;
    localparam int TICK_CEILING = 1023;
    localparam longint Q15_ONE = 32768;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [1:0] {
        CAL_IDLE     = 2'd0,
        CAL_RUNNING  = 2'd1,
        CAL_COMPLETE = 2'd2
    } cal_state_t;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    imucas_stream_if #(.payload_t(in_item_t))  in_ch ();
    imucas_stream_if #(.payload_t(out_item_t)) out_ch ();

    imu_calibrate_and_smooth u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // calibration and filter state mirrored from the block
    cal_state_t            cal_state;
    int                    ticks_since;
    int                    samples_taken;
    int                    axis_sum [AXES];
    axis_t                 axis_offset [AXES];
    bit                    offsets_ok;
    axis_t                 smoothed [AXES];
    logic [INTERVAL_W-1:0] interval_r;
    logic [GRAVITY_W-1:0]  gravity_r;
    logic [ALPHA_W-1:0]    alpha_r;

    out_item_t read_outputs_due [$];
    plan_row_t plan [$];
    int        errors = 0;
    int        cycle_count = 0;
    bit        in_idle_on = 1'b1;
    bit        out_idle_on = 1'b1;

    function automatic void condition_item(input in_item_t it, output bit produced,
                                           output out_item_t res);
        axis_t  raw [AXES];
        axis_t  outv [AXES];
        int     avg;
        longint acc;
        longint weight;
        bit     use_offsets;
        raw[0] = it.accel_x;
        raw[1] = it.accel_y;
        raw[2] = it.accel_z;
        raw[3] = it.gyro_x;
        raw[4] = it.gyro_y;
        raw[5] = it.gyro_z;
        produced = 1'b0;
        res = '0;
        case (it.kind)
            KIND_START:
            begin
                if (cal_state == CAL_IDLE)
                begin
                    cal_state = CAL_RUNNING;
                    ticks_since = 0;
                    samples_taken = 0;
                    offsets_ok = 1'b0;
                    foreach (axis_sum[i])
                        axis_sum[i] = 0;
                end
            end
            KIND_TICK:
            begin
                if (cal_state == CAL_RUNNING)
                begin
                    if (ticks_since < TICK_CEILING)
                        ticks_since++;
                    if (ticks_since >= int'(interval_r))
                    begin
                        foreach (axis_sum[i])
                            axis_sum[i] += raw[i];
                        samples_taken = (samples_taken + 1) & 8'h7F;
                        ticks_since = 0;
                        if (samples_taken >= SAMPLES_PER_CAL)
                        begin
                            foreach (axis_offset[i])
                            begin
                                avg = axis_sum[i] / samples_taken;
                                if (i == AXIS_AZ)
                                    avg -= int'(gravity_r);
                                axis_offset[i] = axis_t'(avg);
                            end
                            offsets_ok = 1'b1;
                            cal_state = CAL_COMPLETE;
                        end
                    end
                end
                else if (cal_state == CAL_COMPLETE)
                    cal_state = CAL_IDLE;
            end
            KIND_READ:
            begin
                use_offsets = it.want_calibrated && offsets_ok;
                weight = (alpha_r > ALPHA_ONE) ? Q15_ONE : longint'(alpha_r);
                foreach (outv[i])
                begin
                    outv[i] = use_offsets ? axis_t'(raw[i] - axis_offset[i]) : raw[i];
                    if (it.want_filtered)
                    begin
                        acc = longint'(smoothed[i]) * (Q15_ONE - weight)
                            + longint'(outv[i]) * weight;
                        smoothed[i] = axis_t'(acc / Q15_ONE);
                        outv[i] = smoothed[i];
                    end
                end
                res.out_accel_x     = outv[0];
                res.out_accel_y     = outv[1];
                res.out_accel_z     = outv[2];
                res.out_gyro_x      = outv[3];
                res.out_gyro_y      = outv[4];
                res.out_gyro_z      = outv[5];
                res.out_temperature = it.temperature;
                res.is_calibrating  = (cal_state == CAL_RUNNING);
                res.is_calibrated   = offsets_ok;
                produced = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic in_item_t uniform(logic [1:0] k, axis_t val, axis_t temp,
                                         bit cal, bit filt);
        in_item_t it;
        it.kind            = k;
        it.accel_x         = val;
        it.accel_y         = val;
        it.accel_z         = val;
        it.gyro_x          = val;
        it.gyro_y          = val;
        it.gyro_z          = val;
        it.temperature     = temp;
        it.want_calibrated = cal;
        it.want_filtered   = filt;
        return it;
    endfunction

    function automatic out_item_t echo(axis_t val, axis_t temp, bit calibrating,
                                       bit calibrated);
        out_item_t r;
        r.out_accel_x     = val;
        r.out_accel_y     = val;
        r.out_accel_z     = val;
        r.out_gyro_x      = val;
        r.out_gyro_y      = val;
        r.out_gyro_z      = val;
        r.out_temperature = temp;
        r.is_calibrating  = calibrating;
        r.is_calibrated   = calibrated;
        return r;
    endfunction

    function automatic axis_t rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return axis_t'($urandom_range(0, 64)) - 16'sd32;
            default: return axis_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_item(logic [1:0] k);
        in_item_t it;
        it.kind            = k;
        it.accel_x         = rand_axis();
        it.accel_y         = rand_axis();
        it.accel_z         = rand_axis();
        it.gyro_x          = rand_axis();
        it.gyro_y          = rand_axis();
        it.gyro_z          = rand_axis();
        it.temperature     = axis_t'($urandom);
        it.want_calibrated = $urandom_range(0, 1);
        it.want_filtered   = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        case (cal_state)
            CAL_IDLE:
                return (r < 45) ? KIND_START : (r < 75) ? KIND_READ :
                       (r < 92) ? KIND_TICK : KIND_UNUSED;
            CAL_RUNNING:
                return (r < 80) ? KIND_TICK : (r < 95) ? KIND_READ :
                       (r < 98) ? KIND_START : KIND_UNUSED;
            default:
                return (r < 45) ? KIND_TICK : (r < 90) ? KIND_READ :
                       (r < 97) ? KIND_START : KIND_UNUSED;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
        int        gap;
        bit        produced;
        out_item_t predicted;
        gap = in_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        condition_item(it, produced, predicted);
        if (produced)
            read_outputs_due.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // drop valid and drain every pending read
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (read_outputs_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic retune(int interval, int gravity, int alpha);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= CFG_DATA_W'(interval);
        @(negedge clk);
        cfg_index <= CFG_GRAVITY;
        cfg_data  <= CFG_DATA_W'(gravity);
        @(negedge clk);
        cfg_index <= CFG_ALPHA;
        cfg_data  <= CFG_DATA_W'(alpha);
        @(negedge clk);
        cfg_we    <= 1'b0;
        interval_r = INTERVAL_W'(interval);
        gravity_r  = GRAVITY_W'(gravity);
        alpha_r    = ALPHA_W'(alpha);
    endtask

    task automatic run_phase(int budget, bit burst);
        for (int n = 0; n < budget; n++)
        begin
            if (burst)
            begin
                in_idle_on  = 1'b0;
                out_idle_on = 1'b0;
            end
            else if (n % 50 == 0)
            begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            offer_item(rand_item(pick_kind()), 1'b0, '0);
        end
        // advance through any running calibration back to idle
        while (cal_state != CAL_IDLE)
            offer_item(rand_item(KIND_TICK), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (read_outputs_due.size() == 0)
            begin
                $error("result transfer with no read pending");
                errors++;
            end
            else
            begin
                want = read_outputs_due.pop_front();
                check_field("out_accel_x", want.out_accel_x, got.out_accel_x);
                check_field("out_accel_y", want.out_accel_y, got.out_accel_y);
                check_field("out_accel_z", want.out_accel_z, got.out_accel_z);
                check_field("out_gyro_x", want.out_gyro_x, got.out_gyro_x);
                check_field("out_gyro_y", want.out_gyro_y, got.out_gyro_y);
                check_field("out_gyro_z", want.out_gyro_z, got.out_gyro_z);
                check_field("out_temperature", want.out_temperature, got.out_temperature);
                check_field("is_calibrating", want.is_calibrating, got.is_calibrating);
                check_field("is_calibrated", want.is_calibrated, got.is_calibrated);
            end
        end
    end

    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = out_idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_INTERVAL;
        cfg_data    = '0;

        cal_state     = CAL_IDLE;
        ticks_since   = 0;
        samples_taken = 0;
        offsets_ok    = 1'b0;
        interval_r    = INTERVAL_RESET;
        gravity_r     = GRAVITY_RESET;
        alpha_r       = ALPHA_RESET;
        foreach (axis_sum[i])
        begin
            axis_sum[i]    = 0;
            axis_offset[i] = '0;
            smoothed[i]    = '0;
        end

        plan.push_back('{uniform(KIND_READ, 16'sh7FFF, 16'sh7FFF, 0, 0), 1'b1,
                         echo(16'sh7FFF, 16'sh7FFF, 0, 0)});
        plan.push_back('{uniform(KIND_READ, 16'sh8000, 16'sh8000, 0, 0), 1'b1,
                         echo(16'sh8000, 16'sh8000, 0, 0)});
        plan.push_back('{uniform(KIND_READ, 16'sh0000, 16'sh0000, 0, 0), 1'b1,
                         echo(16'sh0000, 16'sh0000, 0, 0)});
        plan.push_back('{uniform(KIND_READ, 16'sd1234, -16'sd5, 1, 0), 1'b1,
                         echo(16'sd1234, -16'sd5, 0, 0)});
        plan.push_back('{uniform(KIND_TICK, 16'sh7FFF, 16'sh0000, 0, 0), 1'b0, '0});
        plan.push_back('{uniform(KIND_UNUSED, 16'sh8000, 16'sh7FFF, 1, 1), 1'b0, '0});
        plan.push_back('{uniform(KIND_READ, 16'sh7FFF, 16'sh0001, 0, 1), 1'b0, '0});
        plan.push_back('{uniform(KIND_READ, 16'sh8000, 16'sh8000, 0, 1), 1'b0, '0});
        plan.push_back('{uniform(KIND_READ, 16'sd100, 16'sd25, 1, 1), 1'b0, '0});
        plan.push_back('{uniform(KIND_START, 16'sh0000, 16'sh0000, 0, 0), 1'b0, '0});
        plan.push_back('{uniform(KIND_READ, -16'sd1, -16'sd1, 0, 0), 1'b1,
                         echo(-16'sd1, -16'sd1, 1, 0)});
        plan.push_back('{uniform(KIND_START, 16'sh7FFF, 16'sh7FFF, 1, 1), 1'b0, '0});
        plan.push_back('{uniform(KIND_TICK, 16'sh8000, 16'sh0000, 0, 0), 1'b0, '0});
        plan.push_back('{uniform(KIND_TICK, 16'sh7FFF, 16'sh0000, 0, 0), 1'b0, '0});
        plan.push_back('{uniform(KIND_UNUSED, 16'sh0000, 16'sh0000, 0, 0), 1'b0, '0});
        plan.push_back('{uniform(KIND_READ, 16'sh7FFF, 16'sh8000, 1, 1), 1'b0, '0});
        plan.push_back('{uniform(KIND_READ, 16'sh7FFF, 16'sh7FFF, 0, 0), 1'b1,
                         echo(16'sh7FFF, 16'sh7FFF, 1, 0)});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            offer_item(plan[i].item, plan[i].typed, plan[i].want);

        run_phase(200, 1'b0);
        retune(1, 0, 0);
        run_phase(300, 1'b0);
        retune(0, 32767, 32768);
        run_phase(300, 1'b0);
        retune(2, $urandom_range(0, 32767), 65535);
        run_phase(250, 1'b0);
        retune($urandom_range(3, 5), $urandom_range(0, 32767), $urandom_range(0, 32768));
        run_phase(200, 1'b0);
        retune(1, 16384, 1);
        run_phase(30, 1'b1);

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
